// ===== rtl/lru_key_cache_defines.svh =====
// Assertion helpers for the cache RTL top level.
`ifndef LRU_KEY_CACHE_DEFINES_SVH
`define LRU_KEY_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LKC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_key_cache: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_key_cache: next-cycle check failed");

`endif

// ===== rtl/lkc_pkg.sv =====
package lkc_pkg;

    localparam int KEY_W = 64;
    localparam int OCC_W = 3;
    localparam int CAP_W = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 3'd4;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0] occupancy;
    } lkc_result_t;

endpackage

// ===== rtl/lkc_cfg.sv =====
module lkc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkc_pkg::APB_AW-1:0]  paddr,
    input  logic [lkc_pkg::APB_DW-1:0]  pwdata,
    output logic [lkc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [lkc_pkg::CAP_W-1:0]   capacity
);
    import lkc_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_en && (paddr[2] == REG_CAPACITY))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_CAPACITY:
            begin
                prdata = APB_DW'(capacity_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign capacity = capacity_reg;

endmodule

// ===== rtl/lkc_core.sv =====
module lkc_core #(
    parameter int ENTRIES = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       proc_en,
    input  logic [lkc_pkg::KEY_W-1:0]  key,
    input  logic [lkc_pkg::CAP_W-1:0]  capacity,
    output lkc_pkg::lkc_result_t       result
);
    import lkc_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int EXT_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [KEY_W-1:0]  key_reg  [ENTRIES];
    logic [RANK_W-1:0] rank_reg [ENTRIES];
    logic [RANK_W-1:0] rank_next[ENTRIES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [ENTRIES-1:0] in_use;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] key_wr;
    logic [RANK_W-1:0]  hit_rank;
    logic [RANK_W-1:0]  lru_rank;
    logic [KEY_W-1:0]   victim_key;
    logic [EXT_W-1:0]   cap_eff;
    logic [EXT_W-1:0]   cnt_ext;
    logic [EXT_W-1:0]   cnt_next_ext;
    logic               hit;
    logic               has_room;
    logic               do_insert;
    logic               do_evict;

    // Clamp capacity to 1..ENTRIES.
    always_comb
    begin
        cap_eff = EXT_W'(capacity);
        if (capacity == '0)
        begin
            cap_eff = EXT_W'(1);
        end
        else if (EXT_W'(capacity) > EXT_W'(ENTRIES))
        begin
            cap_eff = EXT_W'(ENTRIES);
        end
    end

    assign cnt_ext  = EXT_W'(count_reg);
    assign has_room = cnt_ext < cap_eff;
    assign lru_rank = RANK_W'(count_reg - CNT_W'(1));

    // Parallel tag compare and victim search over valid slots.
    always_comb
    begin
        hit_rank   = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            in_use[i] = CNT_W'(i) < count_reg;
            match[i]  = in_use[i] && (key_reg[i] == key);
            victim[i] = in_use[i] && (rank_reg[i] == lru_rank);
            hit_rank   = hit_rank | (match[i] ? rank_reg[i] : '0);
            victim_key = victim_key | (victim[i] ? key_reg[i] : '0);
        end
    end

    assign hit       = |match;
    assign do_insert = !hit && has_room;
    assign do_evict  = !hit && !has_room;

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            key_wr[i]    = 1'b0;
            if (hit)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (in_use[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else if (do_insert)
            begin
                if (in_use[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                else if (CNT_W'(i) == count_reg)
                begin
                    rank_next[i] = '0;
                    key_wr[i]    = 1'b1;
                end
            end
            else
            begin
                if (victim[i])
                begin
                    rank_next[i] = '0;
                    key_wr[i]    = 1'b1;
                end
                else if (in_use[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (proc_en)
        begin
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key store carries no reset; count marks which slots hold data.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (proc_en && key_wr[i])
            begin
                key_reg[i] <= key;
            end
        end
    end

    assign cnt_next_ext       = EXT_W'(count_next);
    assign result.hit         = hit;
    assign result.evicted     = do_evict;
    assign result.evicted_key = do_evict ? victim_key : '0;
    assign result.occupancy   = cnt_next_ext[OCC_W-1:0];

endmodule

// ===== rtl/lru_key_cache.sv =====
// lru_key_cache: fully associative key cache with LRU replacement.
// Requests pass through an input register and a result register; the result register
// loads from the input register whenever the result side is not stalled.
// Throughput: 1 request per cycle while the result side keeps up, bound by the state update loop.
// Reset (rst_n, async, active low): empties the cache, zeroes ranks, capacity = 4.
module lru_key_cache #(
    parameter int ENTRIES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkc_pkg::APB_AW-1:0]  paddr,
    input  logic [lkc_pkg::APB_DW-1:0]  pwdata,
    output logic [lkc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lkc_pkg::KEY_W-1:0]   url_key,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic                        evicted,
    output logic [lkc_pkg::KEY_W-1:0]   evicted_key,
    output logic [lkc_pkg::OCC_W-1:0]   occupancy
);
    import lkc_pkg::*;
    `include "lru_key_cache_defines.svh"

    logic [CAP_W-1:0] capacity;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [KEY_W-1:0] s1_key_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    lkc_result_t      res_reg;
    lkc_result_t      res_comb;
    logic             advance;
    logic             in_take;
    logic             proc_en;

    lkc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // The result register may load whenever it is empty or being drained.
    // The input register moves forward with it, so a request can enter
    // every cycle while the result side keeps up.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign proc_en  = s1_valid_reg && advance;

    // Lookup and replacement; cache state commits on proc_en, so the next
    // request in the input register already sees this one's update.
    lkc_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .proc_en  (proc_en),
        .key      (s1_key_reg),
        .capacity (capacity),
        .result   (res_comb)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            // Drain the input stage into the result stage.
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold while stalled, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_key_reg <= url_key;
        end
        if (proc_en)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = res_reg.hit;
    assign evicted     = res_reg.evicted;
    assign evicted_key = res_reg.evicted_key;
    assign occupancy   = res_reg.occupancy;

    // A hit never evicts.
    `LKC_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid_reg && res_reg.hit, !res_reg.evicted)
    // An accepted request lands in the input register.
    `LKC_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_valid_reg)
    // A request blocked in the input register keeps its key.
    `LKC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !advance, $stable(s1_key_reg))

endmodule

// ===== sim/lru_key_cache_tb.sv =====
`timescale 1ns / 100ps

module lru_key_cache_tb;

    import lkc_pkg::*;

    localparam int CACHE_SLOTS = 4;

    // The register index sits in the word address bit of paddr.
    localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR = {~REG_CAPACITY, 2'b00};

    localparam logic [KEY_W-1:0] KEY_ZERO  = '0;
    localparam logic [KEY_W-1:0] KEY_ONES  = '1;
    localparam logic [KEY_W-1:0] KEY_MSB   = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_ALT_A = 64'h5555_5555_5555_5555;
    localparam logic [KEY_W-1:0] KEY_ALT_B = 64'hAAAA_AAAA_AAAA_AAAA;

    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int MAX_PRINTED_ERRS = 200;

    // Shadow copy of the cache plus the queue of results it has promised.
    class cache_scoreboard;
        logic [KEY_W-1:0] slot_key [CACHE_SLOTS];
        int               slot_rank [CACHE_SLOTS];
        int               fill_count;
        logic [CAP_W-1:0] capacity_reg;
        lkc_result_t      awaited_results [$];
        int               error_count;

        function new();
            foreach (slot_key[i])
            begin
                slot_key[i]  = '0;
                slot_rank[i] = 0;
            end
            fill_count   = 0;
            capacity_reg = CAPACITY_RESET;
            error_count  = 0;
        endfunction

        function void write_register(logic index, logic [APB_DW-1:0] value);
            if (index == REG_CAPACITY)
                capacity_reg = value[CAP_W-1:0];
        endfunction

        function int usable_slots();
            int c;
            c = capacity_reg;
            if (c == 0)
                c = 1;
            if (c > CACHE_SLOTS)
                c = CACHE_SLOTS;
            return c;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Update the shadow cache for one accepted request and queue its result.
        function void note_request(logic [KEY_W-1:0] key);
            lkc_result_t res;
            bit          found;
            int          slot;
            int          hit_rank;
            found = 1'b0;
            slot  = 0;
            res   = '0;
            for (int i = 0; i < fill_count; i++)
                if (!found && slot_key[i] === key)
                begin
                    found = 1'b1;
                    slot  = i;
                end
            if (found)
            begin
                // promote the hit entry, age only the ones that were newer
                hit_rank = slot_rank[slot];
                for (int i = 0; i < fill_count; i++)
                    if (slot_rank[i] < hit_rank)
                        slot_rank[i]++;
                slot_rank[slot] = 0;
                res.hit = 1'b1;
            end
            else if (fill_count < usable_slots())
            begin
                for (int i = 0; i < fill_count; i++)
                    slot_rank[i]++;
                slot_key[fill_count]  = key;
                slot_rank[fill_count] = 0;
                fill_count++;
            end
            else
            begin
                // replace the oldest entry in place; occupancy holds
                slot = 0;
                for (int i = 0; i < fill_count; i++)
                    if (slot_rank[i] == fill_count - 1)
                        slot = i;
                res.evicted     = 1'b1;
                res.evicted_key = slot_key[slot];
                for (int i = 0; i < fill_count; i++)
                    if (i != slot)
                        slot_rank[i]++;
                slot_key[slot]  = key;
                slot_rank[slot] = 0;
            end
            res.occupancy = fill_count[OCC_W-1:0];
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what);
            error_count++;
            if (error_count <= MAX_PRINTED_ERRS)
                $display("[%0t] ERROR: %s", $realtime, what);
        endtask

        task check_result(lkc_result_t got);
            lkc_result_t want;
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = awaited_results.pop_front();
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit %b, predicted %b", got.hit, want.hit));
            if (got.evicted !== want.evicted)
                report_mismatch($sformatf("evicted %b, predicted %b",
                                          got.evicted, want.evicted));
            if (got.evicted_key !== want.evicted_key)
                report_mismatch($sformatf("evicted_key %h, predicted %h",
                                          got.evicted_key, want.evicted_key));
            if (got.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                          got.occupancy, want.occupancy));
        endtask
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [KEY_W-1:0]    url_key   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                hit;
    logic                evicted;
    logic [KEY_W-1:0]    evicted_key;
    logic [OCC_W-1:0]    occupancy;

    cache_scoreboard sb = new();

    // Pool of keys reused within a phase so that hits and evictions dominate.
    logic [KEY_W-1:0] key_pool [8];
    int               pool_size;

    // Sender burst shaping.
    int burst_left = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_left = 0;

    lru_key_cache #(.ENTRIES(CACHE_SLOTS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .url_key     (url_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .occupancy   (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs a handshake.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: switch among free-running, random, held and toggling stall
    // stretches so that back pressure lands on every stage of the pipeline.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 8) : $urandom_range(5, 40);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            2:       out_stall <= 1'b1;
            default: out_stall <= ~out_stall;
        endcase
    end

    // Monitor: values read here are those present at the edge, since all
    // updates at this edge are still pending as nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{hit, evicted, evicted_key, occupancy});
    end

    // Two-phase write: setup, then access; the register takes the data at the
    // edge that ends the access phase. The bus is left idle afterwards.
    task apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(addr[APB_AW-1], data);
        @(posedge clk);
    endtask

    // Read the capacity register back and compare with the shadow copy.
    task check_capacity_readback();
        logic [APB_DW-1:0] want;
        want    = '0;
        want[CAP_W-1:0] = sb.capacity_reg;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAPACITY_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            sb.report_mismatch($sformatf("capacity reads %h, written %h", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the capacity with junk in the unused upper bits, then read it back.
    task set_capacity(input int cap);
        logic [APB_DW-1:0] data;
        data = $urandom;
        data[CAP_W-1:0] = cap[CAP_W-1:0];
        apb_write(CAPACITY_ADDR, data);
        check_capacity_readback();
    endtask

    // Present one request and hold it until the block takes it. Valid stays
    // high into the next request, so it is never dropped and raised in a step.
    task send_request(input logic [KEY_W-1:0] key);
        in_valid <= 1'b1;
        url_key  <= key;
        do @(posedge clk); while (in_stall);
        sb.note_request(key);
    endtask

    // Insert a random gap between bursts; some bursts follow back to back.
    task pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        else
            burst_left--;
    endtask

    // Drop valid and hold off until every promised result has been taken,
    // then let the pipeline settle before touching the register.
    task drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task paced_request(input logic [KEY_W-1:0] key);
        pace_sender();
        send_request(key);
    endtask

    // Mostly pool keys; the rest are one-bit neighbours of pool keys,
    // extremes, or fully random keys.
    function logic [KEY_W-1:0] pick_key();
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, pool_size - 1)];
        if (r < 70)
            return k;
        if (r < 80)
            return k ^ (KEY_MSB >> $urandom_range(0, KEY_W - 1));
        if (r < 88)
        begin
            case ($urandom_range(0, 2))
                0:       return KEY_ZERO;
                1:       return KEY_ONES;
                default: return KEY_MSB >> $urandom_range(0, KEY_W - 1);
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int cap_plan [8];
        int cap;
        int waited;

        cap_plan = '{1, 4, 0, 7, 2, 3, 5, 6};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the capacity register.
        check_capacity_readback();

        // Capacity zero acts as one: a single entry that keeps being replaced.
        set_capacity(0);
        paced_request(KEY_ZERO);
        paced_request(KEY_ZERO);
        paced_request(KEY_ONES);
        drain_results();

        // Capacity two: grow to two, hit, then evict the older entry.
        set_capacity(2);
        paced_request(KEY_MSB >> 63);
        paced_request(KEY_ONES);
        paced_request(KEY_MSB);
        drain_results();

        // A write to an address past the register list must not move capacity.
        apb_write(UNMAPPED_ADDR, 32'h0000_0001);
        check_capacity_readback();
        paced_request(KEY_ALT_A);
        drain_results();

        // Capacity above the slot count saturates; fill up, then hit an
        // entry in the middle of the order and the most recent one.
        set_capacity(7);
        paced_request(KEY_ALT_B);
        paced_request(KEY_ZERO);
        paced_request(KEY_ONES);
        paced_request(KEY_ALT_B);
        paced_request(KEY_ALT_B);
        paced_request(KEY_MSB >> 1);
        drain_results();

        // Capacity dropped below occupancy: misses replace, occupancy holds.
        set_capacity(3);
        paced_request(KEY_MSB >> 2);
        paced_request(KEY_MSB >> 3);
        paced_request(KEY_ZERO);
        drain_results();

        // Random phases, each with its own capacity and key pool.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            cap = (p < 8) ? cap_plan[p] : $urandom_range(0, 7);
            if (p % 3 == 0)
                apb_write(UNMAPPED_ADDR, $urandom);
            set_capacity(cap);
            pool_size = $urandom_range(1, 8);
            foreach (key_pool[i])
                key_pool[i] = {$urandom, $urandom};
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                paced_request(pick_key());
            drain_results();
        end

        // Wait out any stragglers, bounded, then let the pipeline settle.
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lkc_pkg.sv
rtl/lkc_cfg.sv
rtl/lkc_core.sv
rtl/lru_key_cache.sv
sim/lru_key_cache_tb.sv
